/* rtl/core/fjpr_pkg.sv */
// Package for the framed joint position receiver: frame constants, state and
// result types shared by the decode logic and the top level.
// No dependencies.
package fjpr_pkg;

  localparam int unsigned FrameSlots = 20;
  localparam int unsigned KeptSlots  = 8;
  localparam int unsigned SlotIdxW   = $clog2(KeptSlots);
  localparam int unsigned CountW     = $clog2(FrameSlots + 1);

  localparam logic [7:0] StartByte  = 8'd127;
  localparam logic [7:0] EndByte    = 8'd126;
  localparam logic [7:0] JointLimit = 8'd100;

  typedef struct packed {
    logic                              in_frame;
    logic [CountW-1:0]                 slot_count;
    logic [KeptSlots-1:0][7:0]         slots;
  } fjpr_state_t;

  typedef struct packed {
    logic       emit;
    logic       frame_ok;
    logic [7:0] joint_a;
    logic [7:0] joint_b;
    logic [7:0] joint_c;
    logic [7:0] joint_d;
    logic [6:0] joint_e;
    logic [7:0] head_pos;
  } fjpr_result_t;

endpackage

/* rtl/core/framed_joint_position_receiver_unit.sv */
// Top level of the framed joint position receiver: input register, frame
// state, result register. Depends on fjpr_pkg and fjpr_decode.
//
// An accepted input transaction passes the input register, then its result
// enters the result register. Throughput: one byte per cycle while the master
// side does not stall; the frame state update in fjpr_decode is the only loop.
// Reset (rst_ni, async, active low): no frame open, count and slots zero,
// both pipeline registers empty.
module framed_joint_position_receiver_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  // slave side: received bytes
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  // master side: one transaction per closed frame
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // [7:0] joint_a, [15:8] joint_b,
                                      // [23:16] joint_c, [31:24] joint_d,
                                      // [38:32] joint_e, [46:39] head_pos,
                                      // [47] zero
  output logic        m_axis_tuser    // [0] frame_ok
);

  // Input register
  logic       in_valid_q, in_valid_d;
  logic [7:0] in_byte_q;

  // Frame state
  fjpr_pkg::fjpr_state_t state_q, state_d;

  // Result register
  logic                   out_valid_q, out_valid_d;
  fjpr_pkg::fjpr_result_t res_q;
  fjpr_pkg::fjpr_result_t res_d;

  logic adv;       // pipeline moves: result register free or being drained
  logic in_take;   // slave transaction this cycle

  assign adv           = !out_valid_q || m_axis_tready;
  assign s_axis_tready = !in_valid_q || adv;
  assign in_take       = s_axis_tvalid && s_axis_tready;

  fjpr_decode u_decode (
    .rx_byte_i (in_byte_q),
    .state_i   (state_q),
    .state_o   (state_d),
    .result_o  (res_d)
  );

  always_comb begin
    if (in_take) begin
      in_valid_d = 1'b1;
    end else if (adv) begin
      in_valid_d = 1'b0;
    end else begin
      in_valid_d = in_valid_q;
    end

    // a byte only produces a result when it closes a frame
    if (adv) begin
      out_valid_d = in_valid_q && res_d.emit;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= '0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      if (adv && in_valid_q) begin
        state_q <= state_d;
      end
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_byte_q <= s_axis_tdata;
    end
    if (adv && in_valid_q && res_d.emit) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = res_q.frame_ok;
  assign m_axis_tdata  = {1'b0, res_q.head_pos, res_q.joint_e, res_q.joint_d,
                          res_q.joint_c, res_q.joint_b, res_q.joint_a};

endmodule

/* rtl/core/fjpr_decode.sv */
// Per-byte frame decode: next frame state and the optional result for one byte.
// Depends on fjpr_pkg.
module fjpr_decode (
  input  logic                 [7:0] rx_byte_i,
  input  fjpr_pkg::fjpr_state_t      state_i,
  output fjpr_pkg::fjpr_state_t      state_o,
  output fjpr_pkg::fjpr_result_t     result_o
);

  logic                        in_frame;
  logic [fjpr_pkg::CountW-1:0] cnt;
  logic                        ok;

  always_comb begin
    state_o  = state_i;
    result_o = '0;
    ok       = 1'b1;

    // start byte reopens the frame at slot 0
    if (rx_byte_i == fjpr_pkg::StartByte) begin
      in_frame = 1'b1;
      cnt      = '0;
    end else begin
      in_frame = state_i.in_frame;
      cnt      = state_i.slot_count;
    end
    state_o.in_frame   = in_frame;
    state_o.slot_count = cnt;

    if (in_frame) begin
      if (rx_byte_i != fjpr_pkg::EndByte) begin
        if (cnt < fjpr_pkg::CountW'(fjpr_pkg::FrameSlots)) begin
          if (cnt < fjpr_pkg::CountW'(fjpr_pkg::KeptSlots)) begin
            state_o.slots[cnt[fjpr_pkg::SlotIdxW-1:0]] = rx_byte_i;
          end
          state_o.slot_count = cnt + fjpr_pkg::CountW'(1);
        end else begin
          // full frame: byte dropped, count wraps
          state_o.slot_count = '0;
        end
      end else begin
        // closing byte lands in a kept slot if the count points at one
        if (cnt < fjpr_pkg::CountW'(fjpr_pkg::KeptSlots)) begin
          state_o.slots[cnt[fjpr_pkg::SlotIdxW-1:0]] = rx_byte_i;
        end
        state_o.slot_count = '0;
        state_o.in_frame   = 1'b0;

        for (int i = 1; i < int'(fjpr_pkg::KeptSlots); i++) begin
          if (state_o.slots[i] > fjpr_pkg::JointLimit) ok = 1'b0;
        end

        result_o.emit = 1'b1;
        if (ok) begin
          result_o.frame_ok = 1'b1;
          result_o.joint_a  = state_o.slots[2];
          result_o.joint_b  = state_o.slots[3];
          result_o.joint_c  = state_o.slots[5];
          result_o.joint_d  = state_o.slots[6];
          result_o.joint_e  = 7'(fjpr_pkg::JointLimit - state_o.slots[7]);
          result_o.head_pos = state_o.slots[4];
        end
      end
    end
  end

endmodule

/* rtl/core/fjpr_checker.sv */
// Port-level checker for the framed joint position receiver, bound to the top.
// Depends on framed_joint_position_receiver_unit ports only.
module fjpr_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [47:0] m_axis_tdata,
  input logic        m_axis_tuser
);

  // stalled result transaction holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  // rejected frame carries all-zero joints
  a_reject_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == 48'd0)
    else $error("rejected frame with nonzero joints");

  // accepted frame: every joint within limit
  a_ok_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |->
      m_axis_tdata[7:0] <= 8'd100 && m_axis_tdata[15:8] <= 8'd100 &&
      m_axis_tdata[23:16] <= 8'd100 && m_axis_tdata[31:24] <= 8'd100 &&
      m_axis_tdata[38:32] <= 7'd100 && m_axis_tdata[46:39] <= 8'd100 &&
      !m_axis_tdata[47])
    else $error("accepted frame joint out of range");

  // input backpressure only while a result waits on the master side
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input stalled without output backpressure");

endmodule

bind framed_joint_position_receiver_unit fjpr_checker u_fjpr_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
